// ===== rtl/slip_angle_lowpass_estimator_assert.svh =====
// Assertion macros for the slip angle estimator checker.
// Needs no other file; included by the files that carry assertions.
`ifndef SLIP_ANGLE_LOWPASS_ESTIMATOR_ASSERT_SVH
`define SLIP_ANGLE_LOWPASS_ESTIMATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SALE_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SALE_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sale_pkg.sv =====
// Shared types, constants and the arctangent table of the slip angle estimator.
// Has no dependencies; used by every RTL module of the block.
package sale_pkg;

  localparam int NUM_WHEELS_DEF   = 4;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_TABLE_LEN   = 24;

  localparam int CORDIC_PRE_SHIFT = 12;
  localparam int CORDIC_XY_W      = 34;
  localparam int CORDIC_Z_W       = 33;

  localparam int DIV_NUM_W = 33;
  localparam int DIV_DEN_W = 21;
  localparam int DIV_QUO_W = 17;

  localparam logic signed [15:0] ANGLE_MAX = 16'sd25736;
  localparam logic [19:0]        TAU_MIN   = 20'd100;
  localparam logic [16:0]        ALPHA_MIN = 17'd66;
  localparam logic [16:0]        ALPHA_ONE = 17'd65536;

  localparam logic [15:0] MIN_SPEED_RESET = 16'd128;
  localparam logic [19:0] TAU_RESET       = 20'd22500;

  localparam logic REG_TAU       = 1'b0;
  localparam logic REG_MIN_SPEED = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } sale_unit_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RUN,
    ST_MUL,
    ST_UPD
  } sale_state_t;

  function automatic logic [30:0] atan_entry(input logic [4:0] idx);
    logic [30:0] v;
    unique case (idx)
      5'd0:    v = 31'd843314857;
      5'd1:    v = 31'd497837829;
      5'd2:    v = 31'd263043837;
      5'd3:    v = 31'd133525159;
      5'd4:    v = 31'd67021687;
      5'd5:    v = 31'd33543516;
      5'd6:    v = 31'd16775851;
      5'd7:    v = 31'd8388437;
      5'd8:    v = 31'd4194283;
      5'd9:    v = 31'd2097149;
      5'd10:   v = 31'd1048576;
      5'd11:   v = 31'd524288;
      5'd12:   v = 31'd262144;
      5'd13:   v = 31'd131072;
      5'd14:   v = 31'd65536;
      5'd15:   v = 31'd32768;
      5'd16:   v = 31'd16384;
      5'd17:   v = 31'd8192;
      5'd18:   v = 31'd4096;
      5'd19:   v = 31'd2048;
      5'd20:   v = 31'd1024;
      5'd21:   v = 31'd512;
      5'd22:   v = 31'd256;
      5'd23:   v = 31'd128;
      default: v = 31'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/slip_angle_lowpass_estimator.sv =====
// Per-wheel slip angle estimator: CORDIC atan2 followed by a first-order low-pass.
// The 33-step restoring divider forming the filter coefficient runs alongside the
// CORDIC. One input is in flight at a time: in_tready is high only when idle,
// which follows the commit of the result. A stalled result holds its output
// register and delays the commit of the next result. Synchronous reset clears the
// sequencer and the wheel filter states and loads the configuration defaults.
module slip_angle_lowpass_estimator #(
  parameter int NUM_WHEELS   = sale_pkg::NUM_WHEELS_DEF,
  parameter int CORDIC_STEPS = sale_pkg::CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // tdata: lateral_patch_vel [16:0], long_ground_vel [33:17], time_step_us [49:34]
  input  logic [55:0] in_tdata,
  // tuser: wheel_sel [1:0]
  input  logic [1:0]  in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata: filtered_slip_angle [15:0]
  output logic [15:0] out_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int WW = (NUM_WHEELS > 1) ? $clog2(NUM_WHEELS) : 1;

  sale_pkg::sale_state_t state_r, state_nxt;

  logic [19:0] tau_r;
  logic [15:0] min_speed_r;

  logic [WW-1:0]      widx_r;
  logic signed [16:0] lat_r;
  logic signed [16:0] lon_r;
  logic [15:0]        dt_r;

  logic signed [15:0] raw_r;
  logic [16:0]        alpha_r;
  logic               raw_ok_r;
  logic               alpha_ok_r;
  logic signed [34:0] prod_r;

  logic signed [15:0] filt_r [NUM_WHEELS];

  logic               out_valid_r;
  logic [15:0]        out_data_r;

  logic               in_acc;
  logic               cfg_wr;
  logic               out_free;
  logic               start;
  logic               commit;

  logic [4:0]         wsel;
  logic signed [17:0] lon_ext;
  logic [17:0]        lon_mag;
  logic [17:0]        lon_floor;
  logic [19:0]        tau_eff;
  logic [sale_pkg::DIV_DEN_W-1:0] den;
  logic [sale_pkg::DIV_NUM_W-1:0] num;
  logic [sale_pkg::DIV_QUO_W-1:0] quo;
  logic [16:0]        alpha_c;
  logic signed [15:0] raw_a;
  logic signed [15:0] prev;
  logic signed [16:0] diff;
  logic signed [34:0] prod_nxt;
  logic signed [34:0] prod_rnd;
  logic signed [19:0] upd_sum;
  logic signed [15:0] upd_sat;

  sale_pkg::sale_unit_stat_t cordic_stat;
  sale_pkg::sale_unit_stat_t div_stat;

  assign in_acc     = in_tvalid && in_tready;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;
  assign out_free   = !out_valid_r || out_tready;

  always_comb begin
    unique case (cfg_paddr[2])
      sale_pkg::REG_TAU:       cfg_prdata = {12'd0, tau_r};
      sale_pkg::REG_MIN_SPEED: cfg_prdata = {16'd0, min_speed_r};
      default:                 cfg_prdata = '0;
    endcase
  end

  always_comb begin
    wsel = 5'(in_tuser);
    for (int k = 0; k < 3; k++) begin
      if (wsel >= 5'(NUM_WHEELS)) begin
        wsel = wsel - 5'(NUM_WHEELS);
      end
    end
  end

  always_comb begin
    lon_ext   = 18'(lon_r);
    lon_mag   = lon_ext[17] ? 18'(-lon_ext) : 18'(lon_ext);
    lon_floor = (lon_mag < {2'b00, min_speed_r}) ? {2'b00, min_speed_r} : lon_mag;
    tau_eff   = (tau_r < sale_pkg::TAU_MIN) ? sale_pkg::TAU_MIN : tau_r;
    den       = 21'(tau_eff) + 21'(dt_r);
    num       = {1'b0, dt_r, 16'd0} + 33'(den[20:1]);
  end

  sale_cordic #(
    .STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (start),
    .x_i     ($signed(lon_floor)),
    .y_i     (lat_r),
    .angle_o (raw_a),
    .stat_o  (cordic_stat)
  );

  sale_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (start),
    .num_i   (num),
    .den_i   (den),
    .quo_o   (quo),
    .stat_o  (div_stat)
  );

  always_comb begin
    if (quo < sale_pkg::ALPHA_MIN) begin
      alpha_c = sale_pkg::ALPHA_MIN;
    end else if (quo > sale_pkg::ALPHA_ONE) begin
      alpha_c = sale_pkg::ALPHA_ONE;
    end else begin
      alpha_c = quo;
    end
  end

  always_comb begin
    prev     = filt_r[widx_r];
    diff     = 17'(raw_r) - 17'(prev);
    prod_nxt = $signed({1'b0, alpha_r}) * diff;
    prod_rnd = prod_r + 35'sd32768;
    upd_sum  = 20'(prev) + 20'($signed(prod_rnd[34:16]));
    if (upd_sum > sale_pkg::ANGLE_MAX) begin
      upd_sat = sale_pkg::ANGLE_MAX;
    end else if (upd_sum < -sale_pkg::ANGLE_MAX) begin
      upd_sat = -sale_pkg::ANGLE_MAX;
    end else begin
      upd_sat = upd_sum[15:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    start     = 1'b0;
    commit    = 1'b0;
    unique case (state_r)
      sale_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = sale_pkg::ST_LOAD;
        end
      end
      sale_pkg::ST_LOAD: begin
        start     = 1'b1;
        state_nxt = sale_pkg::ST_RUN;
      end
      sale_pkg::ST_RUN: begin
        if (raw_ok_r && alpha_ok_r) begin
          state_nxt = sale_pkg::ST_MUL;
        end
      end
      sale_pkg::ST_MUL: begin
        state_nxt = sale_pkg::ST_UPD;
      end
      sale_pkg::ST_UPD: begin
        if (out_free) begin
          commit    = 1'b1;
          state_nxt = sale_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sale_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sale_pkg::ST_IDLE;
      tau_r       <= sale_pkg::TAU_RESET;
      min_speed_r <= sale_pkg::MIN_SPEED_RESET;
      raw_ok_r    <= 1'b0;
      alpha_ok_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_WHEELS; i++) begin
        filt_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        unique case (cfg_paddr[2])
          sale_pkg::REG_TAU:       tau_r       <= cfg_pwdata[19:0];
          sale_pkg::REG_MIN_SPEED: min_speed_r <= cfg_pwdata[15:0];
          default:                 tau_r       <= tau_r;
        endcase
      end
      if (start) begin
        raw_ok_r   <= 1'b0;
        alpha_ok_r <= 1'b0;
      end else begin
        if (cordic_stat.done) begin
          raw_ok_r <= 1'b1;
        end
        if (div_stat.done) begin
          alpha_ok_r <= 1'b1;
        end
      end
      if (commit) begin
        filt_r[widx_r] <= upd_sat;
        out_valid_r    <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (in_acc) begin
      widx_r <= wsel[WW-1:0];
      lat_r  <= $signed(in_tdata[16:0]);
      lon_r  <= $signed(in_tdata[33:17]);
      dt_r   <= in_tdata[49:34];
    end
    if (cordic_stat.done) begin
      raw_r <= raw_a;
    end
    if (div_stat.done) begin
      alpha_r <= alpha_c;
    end
    if (state_r == sale_pkg::ST_MUL) begin
      prod_r <= prod_nxt;
    end
    if (commit) begin
      out_data_r <= upd_sat;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== rtl/sale_div.sv =====
// Restoring divider, one quotient bit per cycle, for the filter coefficient.
// Depends on sale_pkg for widths and the unit status type.
module sale_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start_i,
  input  logic [sale_pkg::DIV_NUM_W-1:0]      num_i,
  input  logic [sale_pkg::DIV_DEN_W-1:0]      den_i,
  output logic [sale_pkg::DIV_QUO_W-1:0]      quo_o,
  output sale_pkg::sale_unit_stat_t           stat_o
);

  localparam int NW = sale_pkg::DIV_NUM_W;
  localparam int DW = sale_pkg::DIV_DEN_W;
  localparam int QW = sale_pkg::DIV_QUO_W;
  localparam int CW = $clog2(NW);

  logic [NW-1:0] num_r, num_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [QW-1:0] quo_r, quo_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;

  logic [DW:0] rem_sh;
  logic [DW:0] rem_sub;
  logic        fits;

  always_comb begin
    rem_sh  = {rem_r, num_r[NW-1]};
    rem_sub = rem_sh - {1'b0, den_r};
    fits    = (rem_sh >= {1'b0, den_r});

    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start_i) begin
      num_nxt  = num_i;
      den_nxt  = den_i;
      rem_nxt  = '0;
      quo_nxt  = '0;
      cnt_nxt  = CW'(NW - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt = {num_r[NW-2:0], 1'b0};
      rem_nxt = fits ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
      quo_nxt = {quo_r[QW-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign quo_o       = quo_r;
  assign stat_o.busy = busy_r;
  assign stat_o.done = done_r;

endmodule

// ===== rtl/sale_cordic.sv =====
// Iterative vectoring CORDIC that returns atan2(y, x) for non-negative x, in radians Q1.14.
// Depends on sale_pkg for the arctangent table, widths and status type.
module sale_cordic #(
  parameter int STEPS = sale_pkg::CORDIC_STEPS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start_i,
  input  logic signed [17:0]        x_i,
  input  logic signed [16:0]        y_i,
  output logic signed [15:0]        angle_o,
  output sale_pkg::sale_unit_stat_t stat_o
);

  localparam int NSTEP = (STEPS > sale_pkg::ATAN_TABLE_LEN) ? sale_pkg::ATAN_TABLE_LEN : STEPS;
  localparam int IW    = $clog2(NSTEP);
  localparam int XW    = sale_pkg::CORDIC_XY_W;
  localparam int ZW    = sale_pkg::CORDIC_Z_W;

  logic signed [XW-1:0] x_r, x_nxt;
  logic signed [XW-1:0] y_r, y_nxt;
  logic signed [ZW-1:0] z_r, z_nxt;
  logic [IW-1:0]        iter_r, iter_nxt;
  logic                 zero_r, zero_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;

  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;
  logic signed [ZW-1:0] at;
  logic signed [ZW-1:0] z_rnd;
  logic signed [16:0]   z_q;

  always_comb begin
    dx = y_r >>> iter_r;
    dy = x_r >>> iter_r;
    at = $signed({2'b00, sale_pkg::atan_entry(5'(iter_r))});

    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    iter_nxt = iter_r;
    zero_nxt = zero_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start_i) begin
      x_nxt    = XW'(x_i) <<< sale_pkg::CORDIC_PRE_SHIFT;
      y_nxt    = XW'(y_i) <<< sale_pkg::CORDIC_PRE_SHIFT;
      z_nxt    = '0;
      iter_nxt = '0;
      zero_nxt = (x_i == '0) && (y_i == '0);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!y_r[XW-1]) begin
        x_nxt = x_r + dx;
        y_nxt = y_r - dy;
        z_nxt = z_r + at;
      end else begin
        x_nxt = x_r - dx;
        y_nxt = y_r + dy;
        z_nxt = z_r - at;
      end
      iter_nxt = iter_r + 1'b1;
      if (iter_r == IW'(NSTEP - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    z_rnd = z_r + 33'sd32768;
    z_q   = z_rnd[ZW-1:16];
    if (zero_r) begin
      angle_o = '0;
    end else if (z_q > sale_pkg::ANGLE_MAX) begin
      angle_o = sale_pkg::ANGLE_MAX;
    end else if (z_q < -sale_pkg::ANGLE_MAX) begin
      angle_o = -sale_pkg::ANGLE_MAX;
    end else begin
      angle_o = z_q[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      iter_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      iter_r <= iter_nxt;
    end
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    zero_r <= zero_nxt;
  end

  assign stat_o.busy = busy_r;
  assign stat_o.done = done_r;

endmodule

// ===== rtl/sale_checker.sv =====
// Port-level checker for the slip angle estimator, bound to its top level.
// Depends on sale_pkg and the assertion macro header.
`include "slip_angle_lowpass_estimator_assert.svh"

module sale_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  logic        out_stall;
  logic [16:0] out_word;
  logic        in_acc;
  logic        angle_ok;

  assign out_stall = out_tvalid && !out_tready;
  assign out_word  = {out_tvalid, out_tdata};
  assign in_acc    = in_tvalid && in_tready;
  assign angle_ok  = ($signed(out_tdata) <= sale_pkg::ANGLE_MAX) &&
                     ($signed(out_tdata) >= -sale_pkg::ANGLE_MAX);

  `SALE_ASSERT_NXT(a_out_hold, clk, rst_n, out_stall, $stable(out_word), "stalled result changed")
  `SALE_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_acc, !in_tready, "ready while busy")
  `SALE_ASSERT_IMP(a_angle_range, clk, rst_n, out_tvalid, angle_ok, "angle outside limits")

endmodule

bind slip_angle_lowpass_estimator sale_checker u_sale_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== verif/tb_top.sv =====
// Self-checking testbench for slip_angle_lowpass_estimator: it streams wheel samples,
// predicts every filtered slip angle and checks each result transaction in order.
// Depends on rtl/sale_pkg.sv and rtl/slip_angle_lowpass_estimator.sv.
`timescale 1ns / 1ps

module tb_top;

  localparam int          WHEEL_COUNT       = sale_pkg::NUM_WHEELS_DEF;
  localparam int          CORDIC_ITERS      = sale_pkg::CORDIC_STEPS_DEF;
  localparam logic [2:0]  TAU_ADDR          = {sale_pkg::REG_TAU, 2'b00};
  localparam logic [2:0]  SPEED_FLOOR_ADDR  = {sale_pkg::REG_MIN_SPEED, 2'b00};
  localparam longint      ANGLE_CLAMP       = 25736;
  localparam longint      TAU_FLOOR         = 100;
  localparam longint      ALPHA_FLOOR       = 66;
  localparam longint      ALPHA_UNITY       = 65536;
  localparam int          LONG_STALL_CYCLES = 500;
  localparam int          DRAIN_CYCLES      = 60;
  localparam int          RANDOM_PHASES     = 6;
  localparam int          PHASE_SAMPLES     = 130;

  typedef struct {
    logic [1:0]         wheel;
    logic signed [16:0] lat;
    logic signed [16:0] lon;
    logic [15:0]        dt;
  } slip_sample_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic [55:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] out_tdata;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  longint atan_q30 [0:23] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128
  };

  logic signed [15:0] wheel_angle_model [WHEEL_COUNT];
  logic [19:0]        tau_setting = sale_pkg::TAU_RESET;
  logic [15:0]        speed_floor_setting = sale_pkg::MIN_SPEED_RESET;

  slip_sample_t       pending_samples [$];
  logic signed [15:0] expected_angles [$];
  slip_sample_t       next_sample;
  logic signed [15:0] oldest_angle;
  logic               in_taken = 1'b0;
  int                 error_count = 0;
  int                 send_gap_left = 0;
  int                 send_burst_left = 0;
  int                 ready_run_left = 0;
  int                 ready_stall_left = 0;
  int                 long_stall_count = 0;
  logic               long_stall_pending = 1'b0;

  slip_angle_lowpass_estimator u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  function automatic logic signed [15:0] predict_filtered_angle(input logic [1:0] wheel,
      input logic signed [16:0] lat, input logic signed [16:0] lon, input logic [15:0] dt);
    longint x, y, z, dx, dy, mag, tau, den, alpha, raw, prev, next;
    int     w;
    w   = int'(wheel) % WHEEL_COUNT;
    mag = longint'(lon);
    if (mag < 0) mag = -mag;
    if (mag < longint'(speed_floor_setting)) mag = longint'(speed_floor_setting);
    if (mag == 0 && lat == 0) begin
      raw = 0;
    end else begin
      x = mag * 4096;
      y = longint'(lat) * 4096;
      z = 0;
      for (int i = 0; i < CORDIC_ITERS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x = x + dx;
          y = y - dy;
          z = z + atan_q30[i];
        end else begin
          x = x - dx;
          y = y + dy;
          z = z - atan_q30[i];
        end
      end
      raw = (z + 32768) >>> 16;
      if (raw > ANGLE_CLAMP) raw = ANGLE_CLAMP;
      if (raw < -ANGLE_CLAMP) raw = -ANGLE_CLAMP;
    end
    tau = longint'(tau_setting);
    if (tau < TAU_FLOOR) tau = TAU_FLOOR;
    den   = tau + longint'(dt);
    alpha = (longint'(dt) * 65536 + den / 2) / den;
    if (alpha < ALPHA_FLOOR) alpha = ALPHA_FLOOR;
    if (alpha > ALPHA_UNITY) alpha = ALPHA_UNITY;
    prev = longint'(wheel_angle_model[w]);
    next = prev + ((alpha * (raw - prev) + 32768) >>> 16);
    if (next > ANGLE_CLAMP) next = ANGLE_CLAMP;
    if (next < -ANGLE_CLAMP) next = -ANGLE_CLAMP;
    wheel_angle_model[w] = next[15:0];
    return next[15:0];
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    $display("mismatch: %s, got %0d, expected %0d", what, got, want);
  endtask

  function automatic slip_sample_t random_sample();
    slip_sample_t s;
    s.wheel = 2'($urandom_range(0, 3));
    case ($urandom_range(0, 5))
      0:       s.lat = 17'($urandom);
      1:       s.lat = 17'($signed($urandom_range(0, 4000)) - 2000);
      2:       s.lat = $urandom_range(0, 1) ? 17'sh0FFFF : 17'sh10000;
      default: s.lat = 17'($signed($urandom_range(0, 40000)) - 20000);
    endcase
    case ($urandom_range(0, 5))
      0:       s.lon = 17'($urandom);
      1:       s.lon = 17'($signed($urandom_range(0, 600)) - 300);
      2: begin
        case ($urandom_range(0, 2))
          0:       s.lon = 17'sh10000;
          1:       s.lon = 17'sh0FFFF;
          default: s.lon = '0;
        endcase
      end
      default: s.lon = 17'($signed($urandom_range(0, 60000)) - 30000);
    endcase
    case ($urandom_range(0, 4))
      0:       s.dt = 16'($urandom_range(0, 65535));
      1:       s.dt = 16'($urandom_range(1, 100));
      default: s.dt = 16'($urandom_range(1000, 20000));
    endcase
    return s;
  endfunction

  task automatic queue_sample(input int wheel, input int lat, input int lon, input int dt);
    slip_sample_t s;
    s.wheel = 2'(wheel);
    s.lat   = 17'(lat);
    s.lon   = 17'(lon);
    s.dt    = 16'(dt);
    pending_samples.push_back(s);
  endtask

  task automatic wait_until_drained();
    while (pending_samples.size() != 0 || expected_angles.size() != 0 || in_tvalid)
      @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (addr == TAU_ADDR) tau_setting = data[19:0];
    else if (addr == SPEED_FLOOR_ADDR) speed_floor_setting = data[15:0];
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic configure(input int tau, input int floor_speed);
    wait_until_drained();
    repeat (40) @(posedge clk);
    apb_write(TAU_ADDR, 32'(tau));
    apb_write(SPEED_FLOOR_ADDR, 32'(floor_speed));
  endtask

  // Sender: bursts of transactions separated by random gaps.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (send_gap_left > 0) begin
        in_tvalid <= 1'b0;
        send_gap_left--;
      end else if (pending_samples.size() > 0) begin
        next_sample = pending_samples.pop_front();
        in_tuser  <= next_sample.wheel;
        in_tdata  <= {6'b0, next_sample.dt, next_sample.lon, next_sample.lat};
        in_tvalid <= 1'b1;
        if (send_burst_left > 0) begin
          send_burst_left--;
        end else begin
          send_burst_left = $urandom_range(0, 12);
          send_gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 90);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: its own run and stall pattern, plus one long hold-off on request.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (long_stall_pending) begin
      out_tready <= 1'b0;
      long_stall_count++;
      if (long_stall_count >= LONG_STALL_CYCLES) begin
        long_stall_pending = 1'b0;
        long_stall_count   = 0;
      end
    end else if (ready_stall_left > 0) begin
      out_tready <= 1'b0;
      ready_stall_left--;
    end else if (ready_run_left > 0) begin
      out_tready <= 1'b1;
      ready_run_left--;
    end else begin
      out_tready <= 1'b1;
      ready_run_left   = $urandom_range(0, 30);
      ready_stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_tvalid && in_tready;
      if (out_tvalid && out_tready) begin
        if (expected_angles.size() == 0) begin
          report_mismatch("result with nothing expected", $signed(out_tdata), 0);
        end else begin
          oldest_angle = expected_angles.pop_front();
          if (out_tdata !== oldest_angle)
            report_mismatch("filtered_slip_angle", $signed(out_tdata), oldest_angle);
        end
      end
      if (in_tvalid && in_tready)
        expected_angles.push_back(predict_filtered_angle(in_tuser, in_tdata[16:0],
                                                         in_tdata[33:17], in_tdata[49:34]));
    end
  end

  initial begin
    for (int w = 0; w < WHEEL_COUNT; w++) wheel_angle_model[w] = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Values at reset, full-scale inputs, zero longitudinal speed and a zero time step.
    queue_sample(0, 0, 0, 1000);
    queue_sample(1, 65535, 65535, 65535);
    queue_sample(2, -65536, -65536, 65535);
    queue_sample(3, 65535, 0, 65535);
    queue_sample(0, -65536, 0, 65535);
    queue_sample(1, 100, -65536, 40000);
    queue_sample(2, 5000, 20, 0);
    queue_sample(3, 256, 256, 1);
    queue_sample(0, -256, 256, 65535);
    queue_sample(1, -1, 127, 30000);
    queue_sample(2, 1, -65536, 20000);

    // Shortest time constant with no speed floor: both velocities zero is legal here.
    configure(0, 0);
    queue_sample(0, 0, 0, 50);
    queue_sample(1, 1, 0, 10);
    queue_sample(2, -1, 0, 10);
    queue_sample(3, -65536, 1, 65535);
    queue_sample(0, 0, 0, 0);
    queue_sample(1, 65535, -1, 65535);

    // A long time constant and the highest floor: the coefficient clamps at its minimum for short time steps.
    configure(1000000, 65535);
    queue_sample(0, 65535, 1, 1);
    queue_sample(1, -65536, -65536, 0);
    queue_sample(2, 300, 65535, 65535);
    queue_sample(3, -300, -65536, 12);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0:       configure(1000000, 65535);
        1:       configure(0, 1);
        2:       configure(22500, 128);
        default: configure(($urandom_range(0, 2) == 0) ? $urandom_range(0, 1000000)
                                                       : $urandom_range(0, 5000),
                           $urandom_range(0, 1) ? $urandom_range(1, 65535)
                                                : $urandom_range(1, 600));
      endcase
      for (int n = 0; n < PHASE_SAMPLES; n++) pending_samples.push_back(random_sample());
      if (phase == 1) begin
        @(posedge clk);
        long_stall_pending = 1'b1;
      end
    end

    wait_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/sale_pkg.sv
rtl/sale_div.sv
rtl/sale_cordic.sv
rtl/slip_angle_lowpass_estimator.sv
rtl/sale_checker.sv
verif/tb_top.sv
